// ===== hdl/csm_pkg.sv =====
// Package for the CSR sparse matrix-vector core: function codes, field widths
// and default parameter values. No dependencies.
`default_nettype none

package csm_pkg;

	// Field widths of the input and result words and of the accumulator.
	localparam int COL_W    = 12;
	localparam int VALUE_W  = 32;
	localparam int ROW_W    = 16;
	localparam int ACC_W    = 64;
	localparam int FRAC_BITS = 16;

	// Defaults for the top-level parameters.
	localparam int VECTOR_DEPTH_DEF = 4096;
	localparam int DATA_WIDTH_DEF   = 32;

	// Function code carried by each input word.
	typedef enum logic [1:0] {
		FUNC_LOAD    = 2'd0,
		FUNC_NONZERO = 2'd1,
		FUNC_EMPTY   = 2'd2,
		FUNC_START   = 2'd3
	} func_t;

endpackage

`default_nettype wire

// ===== hdl/csm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing; used for the x vector store of the CSR core.
`default_nettype none

module csm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/csr_sparse_matvec_core.sv =====
// A nonzero that ends a row, or an empty-row word, moves through stage 1,
// stage 2 (product), stage 3 (row sum) and the output register.
// Throughput: one word per cycle while the output is not held, set by the
// accumulator loop and the one read port of the x store RAM. Reset clears all
// valid flags, the accumulator, the row count and first_row; the x store is not
// cleared. Depends on csm_pkg and csm_ram.
`default_nettype none

module csr_sparse_matvec_core #(
	parameter int VECTOR_DEPTH = csm_pkg::VECTOR_DEPTH_DEF,
	parameter int DATA_WIDTH   = csm_pkg::DATA_WIDTH_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Configuration: first row number.
	input  wire logic                          cfg_we,
	input  wire logic [csm_pkg::ROW_W-1:0]     cfg_wdata,
	// Input words.
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [1:0]                    func,
	input  wire logic [csm_pkg::COL_W-1:0]     col_index,
	input  wire logic [csm_pkg::VALUE_W-1:0]   value,
	input  wire logic                          row_end,
	// Result words.
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [csm_pkg::ROW_W-1:0]          row_index,
	output logic [csm_pkg::VALUE_W-1:0]        y_value,
	output logic                               saturated
);

	localparam int AW    = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;
	localparam int ACC_W = csm_pkg::ACC_W;
	localparam int FB    = csm_pkg::FRAC_BITS;
	// Lowest accumulator bit that must match the sign for the result to fit.
	localparam int LO    = FB + DATA_WIDTH - 1;

	// The whole pipeline moves together whenever the output register is free
	// or is being emptied this cycle, so a finished result never blocks intake
	// unless it is actually being held by the consumer.
	logic advance;
	logic accept;
	csm_pkg::func_t func_in;

	assign advance  = !out_valid || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && in_ready;
	assign func_in  = csm_pkg::func_t'(func);

	// A column beyond the store depth reads as zero and a load there is dropped.
	logic          col_in_range;
	logic [AW-1:0] col_addr;

	assign col_in_range = 32'(col_index) < 32'(VECTOR_DEPTH);
	assign col_addr     = AW'(col_index);

	// Stage 0: the x store is written by load words and read by nonzero words
	// at the accepting edge. A load followed by a nonzero to the same column is
	// safe: the write lands at an earlier edge than the read.
	logic                  ram_wr_en;
	logic                  ram_rd_en;
	logic [DATA_WIDTH-1:0] ram_rd_data;

	assign ram_wr_en = accept && (func_in == csm_pkg::FUNC_LOAD) && col_in_range;
	assign ram_rd_en = accept && (func_in == csm_pkg::FUNC_NONZERO) && col_in_range;

	csm_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (VECTOR_DEPTH)
	) u_x_store (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (col_addr),
		.wr_data (value[DATA_WIDTH-1:0]),
		.rd_en   (ram_rd_en),
		.rd_addr (col_addr),
		.rd_data (ram_rd_data)
	);

	// Stage 1: matrix value waits alongside the RAM read.
	logic                         v_s1;
	csm_pkg::func_t               func_s1;
	logic                         row_end_s1;
	logic                         in_range_s1;
	logic signed [DATA_WIDTH-1:0] a_s1;
	logic signed [DATA_WIDTH-1:0] b_s1;

	assign b_s1 = in_range_s1 ? $signed(ram_rd_data) : '0;

	// Stage 2: registered product.
	logic                    v_s2;
	csm_pkg::func_t          func_s2;
	logic                    row_end_s2;
	logic signed [ACC_W-1:0] prod_s2;

	// Accumulator and row counter, updated as a word leaves stage 2.
	logic [ACC_W-1:0]          acc_q;
	logic [csm_pkg::ROW_W-1:0] rows_done_q;
	logic [csm_pkg::ROW_W-1:0] first_row_q;
	logic [ACC_W-1:0]          sum_next;
	logic                      emit_s2;

	assign sum_next = acc_q + prod_s2;
	assign emit_s2  = v_s2 && ((func_s2 == csm_pkg::FUNC_EMPTY) ||
		((func_s2 == csm_pkg::FUNC_NONZERO) && row_end_s2));

	// Stage 3: finished row sum waiting to be cut to Q16.16 and saturated.
	logic                      v_s3;
	logic [ACC_W-1:0]          sum_s3;
	logic [csm_pkg::ROW_W-1:0] row_s3;

	// The shifted sum fits when every bit from the result sign upward agrees.
	logic                         fits_s3;
	logic signed [DATA_WIDTH-1:0] y_s3;

	always_comb begin
		fits_s3 = (&sum_s3[ACC_W-1:LO]) || !(|sum_s3[ACC_W-1:LO]);
		if (fits_s3) begin
			y_s3 = $signed(sum_s3[LO:FB]);
		end else if (sum_s3[ACC_W-1]) begin
			y_s3 = {1'b1, {(DATA_WIDTH-1){1'b0}}};
		end else begin
			y_s3 = {1'b0, {(DATA_WIDTH-1){1'b1}}};
		end
	end

	// Output register.
	logic [csm_pkg::ROW_W-1:0]   row_index_q;
	logic [csm_pkg::VALUE_W-1:0] y_value_q;
	logic                        saturated_q;
	logic                        out_valid_q;

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign y_value   = y_value_q;
	assign saturated = saturated_q;

	// Control state: valid flags, accumulator, row count and first_row.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
			acc_q       <= '0;
			rows_done_q <= '0;
			first_row_q <= '0;
		end else begin
			if (cfg_we) begin
				first_row_q <= cfg_wdata;
			end
			if (advance) begin
				// Load words are finished once written, so they drop out here.
				v_s1        <= accept && (func_in != csm_pkg::FUNC_LOAD);
				v_s2        <= v_s1;
				v_s3        <= emit_s2;
				out_valid_q <= v_s3;
				if (v_s2) begin
					case (func_s2)
						csm_pkg::FUNC_NONZERO: begin
							acc_q <= row_end_s2 ? '0 : sum_next;
						end
						csm_pkg::FUNC_START: begin
							acc_q       <= '0;
							rows_done_q <= '0;
						end
						default: begin
						end
					endcase
				end
				if (emit_s2) begin
					rows_done_q <= rows_done_q + 1'b1;
				end
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (advance) begin
			func_s1     <= func_in;
			row_end_s1  <= row_end;
			in_range_s1 <= col_in_range;
			a_s1        <= $signed(value[DATA_WIDTH-1:0]);

			func_s2    <= func_s1;
			row_end_s2 <= row_end_s1;
			prod_s2    <= ACC_W'(a_s1 * b_s1);

			// An empty row carries a zero sum, which comes out unsaturated.
			sum_s3 <= (func_s2 == csm_pkg::FUNC_NONZERO) ? sum_next : '0;
			row_s3 <= first_row_q + rows_done_q;

			row_index_q <= row_s3;
			y_value_q   <= csm_pkg::VALUE_W'(y_s3);
			saturated_q <= !fits_s3;
		end
	end

endmodule

`default_nettype wire
